// ===== rtl/ctrc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctrc_pkg: shared types and constants of the cook thermostat relay controller
// Holds the mode encoding, the command codes, the state and result records
// and the fan phase delay function.
// ----------------------------------------------------------------------------
package ctrc_pkg;

	localparam int TEMP_W     = 14;
	localparam int TIME_W     = 16;
	localparam int DELAY_W    = 14;
	localparam int TARGET_W   = 12;
	localparam int PCT_W      = 7;
	localparam int CNT_W      = 5;
	localparam int DIFF_W     = 16;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FAN    = 1'd1;

	localparam logic [TARGET_W-1:0] TARGET_RESET = 12'd1800;
	localparam logic [PCT_W-1:0]    FAN_RESET    = 7'd60;

	localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 14'sd3000;
	localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -14'sd200;
	localparam logic signed [DIFF_W-1:0] BAND_FULL = 16'sd300;
	localparam logic signed [DIFF_W-1:0] BAND_OFF  = 16'sd100;

	localparam logic [CNT_W-1:0] HOLD_LONG      = 5'd20;
	localparam logic [CNT_W-1:0] HOLD_SHORT     = 5'd10;
	localparam logic [CNT_W-1:0] COOLDOWN_TICKS = 5'd30;

	localparam logic [TIME_W-1:0] TIME_RESET = 16'd900;

	localparam int DELAY_BASE       = 1000;
	localparam int DELAY_STEP       = 80;
	localparam int PCT_MAX          = 100;
	localparam int COOL_FAN_PERCENT = 60;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(DELAY_BASE);
	localparam logic [DELAY_W-1:0] COOL_DELAY  =
		DELAY_W'(DELAY_BASE + (PCT_MAX - COOL_FAN_PERCENT) * DELAY_STEP);

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		MODE_STOPPED = 4'b0001,
		MODE_RUNNING = 4'b0010,
		MODE_COOLING = 4'b0100,
		MODE_ERROR   = 4'b1000
	} mode_t;

	localparam logic [1:0] CODE_STOPPED = 2'd0;
	localparam logic [1:0] CODE_RUNNING = 2'd1;
	localparam logic [1:0] CODE_COOLING = 2'd2;
	localparam logic [1:0] CODE_ERROR   = 2'd3;

	typedef struct packed {
		mode_t               mode;
		logic [TIME_W-1:0]   time_left;
		logic [CNT_W-1:0]    cooldown_left;
		logic [CNT_W-1:0]    relay_hold;
		logic                relay_target;
		logic                heater_drive;
		logic                fan_drive;
		logic [DELAY_W-1:0]  fan_delay;
	} state_t;

	typedef struct packed {
		logic [TARGET_W-1:0] target_temp_tenths;
		logic [PCT_W-1:0]    fan_percent;
	} cfg_t;

	typedef struct packed {
		logic                heater_on;
		logic                fan_on;
		logic [DELAY_W-1:0]  fan_delay_us;
		logic [1:0]          mode_code;
		logic [TIME_W-1:0]   seconds_left;
		logic                finished;
	} res_t;

	function automatic logic [1:0] mode_to_code(mode_t m);
		logic [1:0] c;
		unique case (m)
			MODE_RUNNING: c = CODE_RUNNING;
			MODE_COOLING: c = CODE_COOLING;
			MODE_ERROR:   c = CODE_ERROR;
			default:      c = CODE_STOPPED;
		endcase
		return c;
	endfunction

	function automatic logic [DELAY_W-1:0] delay_for(logic [PCT_W-1:0] pct);
		logic [PCT_W-1:0] p;
		p = (pct > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : pct;
		return DELAY_W'(DELAY_BASE) +
			DELAY_W'(PCT_W'(PCT_MAX) - p) * DELAY_W'(DELAY_STEP);
	endfunction

endpackage

// ===== rtl/cook_thermostat_relay_controller_unit.sv =====
// ----------------------------------------------------------------------------
// cook_thermostat_relay_controller_unit: cook timer, thermostat and fan drive
// The input register holds an accepted beat; the next-state logic turns it into a
// result beat in the result register, which presents it to the status side.
// Throughput: one beat per cycle while the status side does not stall; the state
// update logic lies between the input register and the result register.
// Reset clears the mode to stopped, loads 900 s of cook time, turns heater
// and fan off and restores both configuration registers to their defaults.
// ----------------------------------------------------------------------------
module cook_thermostat_relay_controller_unit import ctrc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic signed [TEMP_W-1:0]  temp_sample,
	input  logic [TIME_W-1:0]         cook_seconds,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      heater_on,
	output logic                      fan_on,
	output logic [DELAY_W-1:0]        fan_delay_us,
	output logic [1:0]                mode_code,
	output logic [TIME_W-1:0]         seconds_left,
	output logic                      finished
);

	logic                      valid_s1;
	op_t                       op_s1;
	logic signed [TEMP_W-1:0]  sample_s1;
	logic [TIME_W-1:0]         cook_s1;
	logic                      out_valid_q;
	res_t                      res_q;
	state_t                    state_q;
	state_t                    state_nxt;
	res_t                      res_nxt;
	cfg_t                      cfg_q;
	logic                      advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_temp_tenths <= TARGET_RESET;
			cfg_q.fan_percent        <= FAN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TARGET: cfg_q.target_temp_tenths <= cfg_data[TARGET_W-1:0];
				CFG_FAN:    cfg_q.fan_percent        <= cfg_data[PCT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			op_s1     <= op_t'(operation);
			sample_s1 <= temp_sample;
			cook_s1   <= cook_seconds;
		end
	end

	ctrc_step u_step (
		.cur    (state_q),
		.cfg    (cfg_q),
		.op     (op_s1),
		.sample (sample_s1),
		.cook   (cook_s1),
		.nxt    (state_nxt),
		.res    (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= MODE_STOPPED;
			state_q.time_left     <= TIME_RESET;
			state_q.cooldown_left <= '0;
			state_q.relay_hold    <= '0;
			state_q.relay_target  <= 1'b0;
			state_q.heater_drive  <= 1'b0;
			state_q.fan_drive     <= 1'b0;
			state_q.fan_delay     <= DELAY_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_nxt;
	end

	assign out_valid    = out_valid_q;
	assign heater_on    = res_q.heater_on;
	assign fan_on       = res_q.fan_on;
	assign fan_delay_us = res_q.fan_delay_us;
	assign mode_code    = res_q.mode_code;
	assign seconds_left = res_q.seconds_left;
	assign finished     = res_q.finished;

	// A finished beat always reports the cool-down with no time left.
	a_finish_cooling: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.finished |->
			res_q.mode_code == CODE_COOLING && res_q.seconds_left == '0)
		else $error("finished beat outside cool-down");

	// The cool-down always runs the fan.
	a_cooling_fan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.mode_code == CODE_COOLING |-> res_q.fan_on)
		else $error("fan off during cool-down");

	// The input side stalls only behind a held beat that cannot move on.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked beat");

endmodule

// ===== rtl/ctrc_step.sv =====
// ----------------------------------------------------------------------------
// ctrc_step: next-state logic of the cook thermostat relay controller
// Applies one command beat to the current state and forms the result beat.
// ----------------------------------------------------------------------------
module ctrc_step import ctrc_pkg::*; (
	input  state_t                    cur,
	input  cfg_t                      cfg,
	input  op_t                       op,
	input  logic signed [TEMP_W-1:0]  sample,
	input  logic [TIME_W-1:0]         cook,
	output state_t                    nxt,
	output res_t                      res
);

	logic                      bad;
	logic                      done;
	logic signed [DIFF_W-1:0]  diff;
	logic [TIME_W-1:0]         tl_dec;
	logic [DELAY_W-1:0]        run_delay;

	assign bad       = (sample >= TEMP_HIGH) || (sample <= TEMP_LOW);
	assign diff      = $signed({{(DIFF_W-TARGET_W){1'b0}}, cfg.target_temp_tenths})
		- DIFF_W'(sample);
	assign tl_dec    = (cur.time_left != '0) ? cur.time_left - TIME_W'(1) : cur.time_left;
	assign run_delay = delay_for(cfg.fan_percent);

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		case (op)
			OP_TICK: begin
				if (bad)
					nxt.mode = MODE_ERROR;
				unique case (nxt.mode)
					MODE_RUNNING: begin
						nxt.time_left = tl_dec;
						if (tl_dec == '0) begin
							nxt.mode          = MODE_COOLING;
							nxt.cooldown_left = COOLDOWN_TICKS;
							done              = 1'b1;
						end
						if (cur.relay_hold != '0) begin
							nxt.relay_hold = cur.relay_hold - CNT_W'(1);
						end else if (diff > BAND_FULL) begin
							if (!cur.relay_target) begin
								nxt.relay_target = 1'b1;
								nxt.relay_hold   = HOLD_LONG;
							end
						end else if (diff <= BAND_OFF) begin
							if (cur.relay_target) begin
								nxt.relay_target = 1'b0;
								nxt.relay_hold   = HOLD_SHORT;
							end
						end else begin
							if (!cur.relay_target) begin
								nxt.relay_target = 1'b1;
								nxt.relay_hold   = HOLD_SHORT;
							end
						end
						nxt.heater_drive = nxt.relay_target;
						nxt.fan_drive    = 1'b1;
						nxt.fan_delay    = run_delay;
					end
					MODE_COOLING: begin
						if (cur.cooldown_left != '0)
							nxt.cooldown_left = cur.cooldown_left - CNT_W'(1);
						else
							nxt.mode = MODE_STOPPED;
						nxt.heater_drive = 1'b0;
						nxt.fan_drive    = 1'b1;
						nxt.fan_delay    = COOL_DELAY;
					end
					default: begin
						nxt.heater_drive = 1'b0;
						nxt.fan_drive    = 1'b0;
					end
				endcase
			end
			OP_START: begin
				nxt.time_left = cook;
				nxt.mode      = MODE_RUNNING;
			end
			OP_STOP: begin
				nxt.mode = MODE_STOPPED;
			end
			default: begin
			end
		endcase
	end

	assign res.heater_on    = nxt.heater_drive;
	assign res.fan_on       = nxt.fan_drive;
	assign res.fan_delay_us = nxt.fan_delay;
	assign res.mode_code    = mode_to_code(nxt.mode);
	assign res.seconds_left = nxt.time_left;
	assign res.finished     = done;

endmodule

// ===== tb/cook_status_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cook_status_checker: status prediction and comparison for the cook controller
// Watches the register port and both beat channels of the controller. Every
// accepted command beat is run through a local copy of the cook timer,
// thermostat relay and fan logic, and the resulting status is queued. Every
// accepted status beat is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module cook_status_checker import ctrc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [1:0]               operation,
	input  logic signed [TEMP_W-1:0] temp_sample,
	input  logic [TIME_W-1:0]        cook_seconds,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     heater_on,
	input  logic                     fan_on,
	input  logic [DELAY_W-1:0]       fan_delay_us,
	input  logic [1:0]               mode_code,
	input  logic [TIME_W-1:0]        seconds_left,
	input  logic                     finished,
	output int                       fail_count,
	output int                       waiting,
	output int                       checked,
	output int                       cooks_done
);

	logic [TARGET_W-1:0] cfg_target;
	logic [PCT_W-1:0]    cfg_fan_pct;

	logic [1:0]          m_mode;
	logic [TIME_W-1:0]   m_time_left;
	logic [CNT_W-1:0]    m_cool_left;
	logic [CNT_W-1:0]    m_hold;
	logic                m_relay;
	logic                m_heater;
	logic                m_fan;
	logic [DELAY_W-1:0]  m_delay;

	res_t expected_status[$];
	res_t want;

	function automatic logic [DELAY_W-1:0] phase_delay(int pct);
		int p;
		p = (pct > PCT_MAX) ? PCT_MAX : pct;
		return DELAY_W'(DELAY_BASE + (PCT_MAX - p) * DELAY_STEP);
	endfunction

	function automatic res_t step_cooker(logic [1:0] op, logic signed [TEMP_W-1:0] sample,
			logic [TIME_W-1:0] secs);
		res_t r;
		int diff;
		logic done;
		done = 1'b0;
		case (op_t'(op))
			OP_TICK: begin
				if (int'(sample) >= int'(TEMP_HIGH) || int'(sample) <= int'(TEMP_LOW))
					m_mode = CODE_ERROR;
				case (m_mode)
					CODE_RUNNING: begin
						if (m_time_left != 0)
							m_time_left = m_time_left - 1'b1;
						if (m_time_left == 0) begin
							m_mode = CODE_COOLING;
							m_cool_left = COOLDOWN_TICKS;
							done = 1'b1;
						end
						// The relay may only change once its hold time has run out.
						if (m_hold != 0) begin
							m_hold = m_hold - 1'b1;
						end else begin
							diff = int'(cfg_target) - int'(sample);
							if (diff > int'(BAND_FULL)) begin
								if (!m_relay) begin
									m_relay = 1'b1;
									m_hold = HOLD_LONG;
								end
							end else if (diff <= int'(BAND_OFF)) begin
								if (m_relay) begin
									m_relay = 1'b0;
									m_hold = HOLD_SHORT;
								end
							end else if (!m_relay) begin
								m_relay = 1'b1;
								m_hold = HOLD_SHORT;
							end
						end
						m_heater = m_relay;
						m_fan = 1'b1;
						m_delay = phase_delay(int'(cfg_fan_pct));
					end
					CODE_COOLING: begin
						if (m_cool_left != 0)
							m_cool_left = m_cool_left - 1'b1;
						else
							m_mode = CODE_STOPPED;
						m_heater = 1'b0;
						m_fan = 1'b1;
						m_delay = phase_delay(COOL_FAN_PERCENT);
					end
					default: begin
						m_heater = 1'b0;
						m_fan = 1'b0;
					end
				endcase
			end
			OP_START: begin
				m_time_left = secs;
				m_mode = CODE_RUNNING;
			end
			OP_STOP: m_mode = CODE_STOPPED;
			default: ;
		endcase
		r.heater_on = m_heater;
		r.fan_on = m_fan;
		r.fan_delay_us = m_delay;
		r.mode_code = m_mode;
		r.seconds_left = m_time_left;
		r.finished = done;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_target = TARGET_RESET;
			cfg_fan_pct = FAN_RESET;
			m_mode = CODE_STOPPED;
			m_time_left = TIME_RESET;
			m_cool_left = '0;
			m_hold = '0;
			m_relay = 1'b0;
			m_heater = 1'b0;
			m_fan = 1'b0;
			m_delay = DELAY_RESET;
			expected_status.delete();
			waiting = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_TARGET: cfg_target = cfg_data[TARGET_W-1:0];
					CFG_FAN:    cfg_fan_pct = cfg_data[PCT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_status.size() == 0) begin
					$error("status beat arrived with no command beat outstanding");
					fail_count++;
				end else begin
					want = expected_status.pop_front();
					check_field("heater_on", want.heater_on, heater_on);
					check_field("fan_on", want.fan_on, fan_on);
					check_field("fan_delay_us", want.fan_delay_us, fan_delay_us);
					check_field("mode_code", want.mode_code, mode_code);
					check_field("seconds_left", want.seconds_left, seconds_left);
					check_field("finished", want.finished, finished);
					checked++;
					if (want.finished)
						cooks_done++;
				end
			end
			if (in_valid && !in_stall)
				expected_status.push_back(step_cooker(operation, temp_sample, cook_seconds));
			waiting = expected_status.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the cook thermostat relay controller
// Drives a directed set of commands covering sample limits, zero and maximum
// cook times, error entry and exit and the unused command code, then random
// cook sessions under changing target and fan settings, with random gaps on
// the command side and random stalls on the status side.
// ----------------------------------------------------------------------------
module tb_top import ctrc_pkg::*; ();

	localparam int STALL_LIMIT = 2000;
	localparam int BEAT_GOAL   = 1850;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               operation;
	logic signed [TEMP_W-1:0] temp_sample;
	logic [TIME_W-1:0]        cook_seconds;
	logic                     out_valid;
	logic                     out_stall;
	logic                     heater_on;
	logic                     fan_on;
	logic [DELAY_W-1:0]       fan_delay_us;
	logic [1:0]               mode_code;
	logic [TIME_W-1:0]        seconds_left;
	logic                     finished;

	int fail_count;
	int waiting;
	int checked;
	int cooks_done;
	int quiet_cycles;
	int n_beats;
	int n_sessions;
	int cur_target;
	logic steady_feed;

	cook_thermostat_relay_controller_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.temp_sample  (temp_sample),
		.cook_seconds (cook_seconds),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.heater_on    (heater_on),
		.fan_on       (fan_on),
		.fan_delay_us (fan_delay_us),
		.mode_code    (mode_code),
		.seconds_left (seconds_left),
		.finished     (finished)
	);

	cook_status_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.temp_sample  (temp_sample),
		.cook_seconds (cook_seconds),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.heater_on    (heater_on),
		.fan_on       (fan_on),
		.fan_delay_us (fan_delay_us),
		.mode_code    (mode_code),
		.seconds_left (seconds_left),
		.finished     (finished),
		.fail_count   (fail_count),
		.waiting      (waiting),
		.checked      (checked),
		.cooks_done   (cooks_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAIL cook_thermostat_relay_controller_unit");
				$finish;
			end
		end
	end

	initial begin : status_side
		int r;
		int n;
		out_stall = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			n = (r < 8) ? 200 : $urandom_range(0, 6);
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b0;
			end
			r = $urandom_range(0, 99);
			n = (r < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			repeat (n) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (steady_feed)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// Called at a falling edge; returns at a falling edge after the beat is taken.
	task automatic send_beat(op_t op, int sample, int secs);
		int gap;
		operation <= op;
		temp_sample <= TEMP_W'(sample);
		cook_seconds <= TIME_W'(secs);
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (op != OP_NONE)
			n_beats++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle_idle();
		if (in_valid)
			in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_config(int target, int pct);
		settle_idle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_TARGET;
		cfg_data <= CFG_DATA_W'(target);
		@(negedge clk);
		cfg_index <= CFG_FAN;
		cfg_data <= CFG_DATA_W'(($urandom_range(0, 31) << PCT_W) | pct);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		cur_target = target & ((1 << TARGET_W) - 1);
	endtask

	task automatic random_config();
		int r;
		int t;
		int p;
		r = $urandom_range(0, 99);
		if (r < 10)
			t = 0;
		else if (r < 20)
			t = 3000;
		else if (r < 25)
			t = (1 << TARGET_W) - 1;
		else if (r < 30)
			t = $urandom_range(0, (1 << TARGET_W) - 1);
		else
			t = $urandom_range(1200, 2400);
		r = $urandom_range(0, 99);
		if (r < 10)
			p = 0;
		else if (r < 20)
			p = PCT_MAX;
		else if (r < 25)
			p = (1 << PCT_W) - 1;
		else
			p = $urandom_range(0, (1 << PCT_W) - 1);
		write_config(t, p);
	endtask

	task automatic noise_beat();
		send_beat(op_t'($urandom_range(0, 3)), $urandom_range(0, (1 << TEMP_W) - 1),
			$urandom_range(0, 65535));
	endtask

	task automatic bad_sample_tick();
		if ($urandom_range(0, 1))
			send_beat(OP_TICK, $urandom_range(3000, 8191), $urandom_range(0, 65535));
		else
			send_beat(OP_TICK, -int'($urandom_range(200, 8192)), $urandom_range(0, 65535));
	endtask

	// One cook: start, ticks near the target through the cool-down (long cooks stop early),
	// with some bad samples, stops, restarts and junk commands mixed in; or just noise beats.
	task automatic cook_session();
		int r;
		int secs;
		int ticks;
		int s;
		n_sessions++;
		random_config();
		steady_feed = ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 7) == 0) begin
			repeat (20) noise_beat();
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 10)
			secs = 0;
		else if (r < 80)
			secs = $urandom_range(1, 40);
		else if (r < 95)
			secs = $urandom_range(41, 250);
		else
			secs = $urandom_range(251, 65535);
		repeat ($urandom_range(0, 2))
			send_beat(OP_TICK, cur_target, $urandom_range(0, 65535));
		send_beat(OP_START, $urandom_range(0, (1 << TEMP_W) - 1), secs);
		ticks = (secs > 250) ? $urandom_range(5, 40) : secs + 32 + $urandom_range(0, 3);
		repeat (ticks) begin
			r = $urandom_range(0, 99);
			if (r < 3) begin
				bad_sample_tick();
			end else if (r < 6) begin
				send_beat(OP_NONE, $urandom_range(0, (1 << TEMP_W) - 1),
					$urandom_range(0, 65535));
			end else if (r < 7) begin
				send_beat(OP_STOP, $urandom_range(0, (1 << TEMP_W) - 1),
					$urandom_range(0, 65535));
			end else if (r < 9) begin
				send_beat(OP_START, $urandom_range(0, (1 << TEMP_W) - 1),
					$urandom_range(0, 20));
			end else begin
				s = cur_target - ($urandom_range(0, 700) - 200);
				if (s > 8191)
					s = 8191;
				if (s < -8192)
					s = -8192;
				send_beat(OP_TICK, s, $urandom_range(0, 65535));
			end
		end
		if (secs > 250)
			send_beat(OP_STOP, 0, 0);
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_TARGET;
		cfg_data = '0;
		in_valid = 1'b0;
		operation = OP_TICK;
		temp_sample = '0;
		cook_seconds = '0;
		steady_feed = 1'b0;
		cur_target = TARGET_RESET;
		n_beats = 0;
		n_sessions = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, first under the default target and fan settings.
		send_beat(OP_TICK, 250, 0);
		send_beat(OP_NONE, -8192, 65535);
		send_beat(OP_START, 8191, 0);
		send_beat(OP_TICK, 1000, 0);
		send_beat(OP_TICK, 1000, 0);
		send_beat(OP_STOP, 0, 0);
		send_beat(OP_START, 0, 65535);
		send_beat(OP_TICK, 2999, 0);
		send_beat(OP_TICK, 3000, 0);
		send_beat(OP_TICK, -199, 0);
		send_beat(OP_START, 0, 3);
		send_beat(OP_TICK, -200, 0);
		send_beat(OP_STOP, 0, 0);
		send_beat(OP_TICK, 1700, 0);
		write_config(0, (1 << PCT_W) - 1);
		send_beat(OP_START, 0, 2);
		send_beat(OP_TICK, -150, 0);
		send_beat(OP_TICK, -199, 0);
		send_beat(OP_TICK, -150, 0);
		write_config((1 << TARGET_W) - 1, 0);
		send_beat(OP_START, 0, 1);
		send_beat(OP_TICK, 2999, 0);
		send_beat(OP_NONE, 0, 0);

		while (n_beats < BEAT_GOAL)
			cook_session();

		steady_feed = 1'b0;
		if (in_valid)
			in_valid <= 1'b0;
		while (waiting != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Covered %0d command beats in %0d cook sessions under changing settings;",
			n_beats, n_sessions);
		$display("%0d status beats checked, %0d of them ending a cook.", checked, cooks_done);
		if (fail_count == 0)
			$display("PASS cook_thermostat_relay_controller_unit");
		else
			$display("FAIL cook_thermostat_relay_controller_unit");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ctrc_pkg.sv
rtl/ctrc_step.sv
rtl/cook_thermostat_relay_controller_unit.sv
tb/cook_status_checker.sv
tb/tb_top.sv
